[sv/mse_pkg.sv]
// shared constants, codes and types of the multi stack engine
`default_nettype none
package mse_pkg;

	localparam int NUM_STACKS  = 16;
	localparam int STACK_DEPTH = 256;

	localparam int FUNC_W = 2;
	localparam int SID_W  = 4;
	localparam int DATA_W = 32;

	localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int IDX_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH = 2'd0,
		FUNC_TOP  = 2'd1,
		FUNC_POP  = 2'd2
	} func_t;

	// one access of the shared word memory
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	// result marker, aligned with the registered memory read data
	typedef struct packed {
		logic strobe;
		logic status;
	} res_t;

endpackage
`default_nettype wire

[sv/multi_stack_engine.sv]
// multi stack engine top level: count file, shared stack memory, result port
// a request is taken in every cycle: busy stays low, the count file updates at the accept edge
// a result (top value or full-push flag) strobes in the cycle after its transaction is accepted,
// aligned with the registered read of the single-port stack memory
// asynchronous reset clears every stack count and the strobe at once, with no clearing pass
// stack memory contents are not reset; only words below a count are ever read
`default_nettype none
module multi_stack_engine (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic        [mse_pkg::FUNC_W-1:0]  func,
	input  wire logic        [mse_pkg::SID_W-1:0]   stack_id,
	input  wire logic signed [mse_pkg::DATA_W-1:0]  push_value,
	output logic                                    strobe,
	output logic signed      [mse_pkg::DATA_W-1:0]  top_value,
	output logic                                    status
);

	mse_pkg::mem_req_t          mem_req;
	mse_pkg::res_t              res;
	logic [mse_pkg::DATA_W-1:0] rdata;

	assign busy = 1'b0;

	mse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (start && !busy),
		.func       (func),
		.stack_id   (stack_id),
		.push_value (push_value),
		.mem_req    (mem_req),
		.res        (res)
	);

	mse_ram #(
		.DATA_W (mse_pkg::DATA_W),
		.DEPTH  (mse_pkg::MEM_DEPTH),
		.ADDR_W (mse_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	assign strobe    = res.strobe;
	assign status    = res.status;
	assign top_value = res.status ? '0 : signed'(rdata);

endmodule
`default_nettype wire

[sv/mse_ram.sv]
// generic single-port synchronous ram with registered read data
`default_nettype none
module mse_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[sv/mse_ctrl.sv]
// request decode, per-stack count file and memory address generation
`default_nettype none
module mse_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [mse_pkg::FUNC_W-1:0]  func,
	input  wire logic [mse_pkg::SID_W-1:0]   stack_id,
	input  wire logic [mse_pkg::DATA_W-1:0]  push_value,
	output mse_pkg::mem_req_t                mem_req,
	output mse_pkg::res_t                    res
);

	logic [mse_pkg::CNT_W-1:0]  count_q [mse_pkg::NUM_STACKS];
	logic [mse_pkg::IDX_W-1:0]  idx;
	logic [mse_pkg::CNT_W-1:0]  cnt;
	logic [mse_pkg::PTR_W-1:0]  ptr;
	logic [mse_pkg::ADDR_W-1:0] base;
	logic                       sid_ok;
	logic                       full;
	logic                       empty;
	logic                       do_push;
	logic                       do_top;
	logic                       do_pop;
	logic                       do_drop;
	logic                       strobe_s1;
	logic                       status_s1;

	assign sid_ok = 32'(stack_id) < mse_pkg::NUM_STACKS;
	assign idx    = mse_pkg::IDX_W'(stack_id);
	assign cnt    = sid_ok ? count_q[idx] : '0;
	assign full   = cnt >= mse_pkg::CNT_W'(mse_pkg::STACK_DEPTH);
	assign empty  = cnt == '0;
	assign base   = mse_pkg::ADDR_W'(idx) * mse_pkg::ADDR_W'(mse_pkg::STACK_DEPTH);

	always_comb begin
		do_push = 1'b0;
		do_top  = 1'b0;
		do_pop  = 1'b0;
		do_drop = 1'b0;
		if (accept && sid_ok) begin
			unique case (func)
				mse_pkg::FUNC_PUSH: begin
					do_push = !full;
					do_drop = full;
				end
				mse_pkg::FUNC_TOP: begin
					do_top = !empty;
				end
				// pop, and the spare code which acts as pop
				default: begin
					do_pop = !empty;
				end
			endcase
		end
	end

	// push writes above the top, read top addresses the word below the count
	assign ptr = do_push ? mse_pkg::PTR_W'(cnt) : mse_pkg::PTR_W'(cnt - 1'b1);

	assign mem_req.we    = do_push;
	assign mem_req.re    = do_top;
	assign mem_req.addr  = base + mse_pkg::ADDR_W'(ptr);
	assign mem_req.wdata = push_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mse_pkg::NUM_STACKS; i++) begin
				count_q[i] <= '0;
			end
			strobe_s1 <= 1'b0;
			status_s1 <= 1'b0;
		end else begin
			if (do_push) begin
				count_q[idx] <= cnt + 1'b1;
			end else if (do_pop) begin
				count_q[idx] <= cnt - 1'b1;
			end
			strobe_s1 <= do_top || do_drop;
			status_s1 <= do_drop;
		end
	end

	assign res.strobe = strobe_s1;
	assign res.status = status_s1;

endmodule
`default_nettype wire

[sv/mse_checker.sv]
// port-level checker of the multi stack engine and its bind
`default_nettype none
module mse_port_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic        [mse_pkg::FUNC_W-1:0]  func,
	input wire logic                               strobe,
	input wire logic signed [mse_pkg::DATA_W-1:0]  top_value,
	input wire logic                               status
);

	// every result belongs to the transaction of the cycle before
	a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy))
		else $error("result without a transaction one cycle earlier");

	// a full flag only comes from a push
	a_full_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> $past(func) == mse_pkg::FUNC_PUSH)
		else $error("full flag not caused by a push");

	// a returned top value only comes from a read top
	a_top_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !status |-> $past(func) == mse_pkg::FUNC_TOP)
		else $error("top value not caused by a read top");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status |-> top_value == '0)
		else $error("full flag with nonzero top value");

	// a pop, or the spare code acting as pop, never answers
	a_pop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func != mse_pkg::FUNC_PUSH && func != mse_pkg::FUNC_TOP
		|=> !strobe)
		else $error("result after a pop");

endmodule

bind multi_stack_engine mse_port_checker u_mse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.func       (func),
	.strobe     (strobe),
	.top_value  (top_value),
	.status     (status)
);
`default_nettype wire
